/* hdl/seven_segment_number_to_lines_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment number-to-lines core
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_NUMBER_TO_LINES_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_NUMBER_TO_LINES_CORE_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SSNL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ssnl: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define SSNL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssnl: next-cycle check failed");

`endif

/* hdl/ssnl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssnl_pkg
// Shared widths, types, the digit-to-segment table and segment geometry.
// ----------------------------------------------------------------------------
package ssnl_pkg;

  localparam int NUM_W          = 27;
  localparam int ORG_W          = 12;
  localparam int COORD_W        = 13;
  localparam int COLOR_W        = 32;
  localparam int SEG_LEN_W      = 6;
  localparam int DIGIT_CNT_W    = 4;
  localparam int DIGIT_W        = 4;
  localparam int NUM_SEGS       = 7;
  localparam int GEOM_W         = 8;

  localparam int MAX_DIGITS_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [SEG_LEN_W-1:0] SEG_LEN_RESET = 6'd8;
  localparam logic [COORD_W-1:0]   DIGIT_GAP     = 13'd6;

  // Binary bits folded into the BCD register per conversion step.
  localparam int BITS_PER_STEP = 3;
  localparam int CONV_STEPS    = NUM_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS);

  typedef enum logic [2:0] {
    SEG_MID   = 3'd0,
    SEG_UR    = 3'd1,
    SEG_TOP   = 3'd2,
    SEG_UL    = 3'd3,
    SEG_LL    = 3'd4,
    SEG_BOT   = 3'd5,
    SEG_LR    = 3'd6
  } seg_e;

  typedef struct packed {
    logic [DIGIT_CNT_W-1:0] count;
    logic [ORG_W-1:0]       ox;
    logic [ORG_W-1:0]       oy;
    logic [COLOR_W-1:0]     color;
  } item_hdr_t;

  typedef struct packed {
    logic [GEOM_W-1:0] x0;
    logic [GEOM_W-1:0] y0;
    logic [GEOM_W-1:0] x1;
    logic [GEOM_W-1:0] y1;
  } seg_geom_t;

  // Largest number shown with n digits: 10^n - 1.
  function automatic longint unsigned max_value(input int n);
    longint unsigned v;
    v = 1;
    for (int i = 0; i < n; i++) begin
      v = v * 10;
    end
    return v - 1;
  endfunction

  function automatic logic [NUM_SEGS-1:0] seg_mask(input logic [DIGIT_W-1:0] d);
    logic [NUM_SEGS-1:0] m;
    unique case (d)
      4'd0:    m = 7'd126;
      4'd1:    m = 7'd66;
      4'd2:    m = 7'd55;
      4'd3:    m = 7'd103;
      4'd4:    m = 7'd75;
      4'd5:    m = 7'd109;
      4'd6:    m = 7'd125;
      4'd7:    m = 7'd70;
      4'd8:    m = 7'd127;
      4'd9:    m = 7'd79;
      default: m = 7'd0;
    endcase
    return m;
  endfunction

  // Line end points of one segment relative to the digit's top-left corner.
  function automatic seg_geom_t seg_geom(input seg_e seg, input logic [SEG_LEN_W-1:0] s);
    seg_geom_t g;
    logic [GEOM_W-1:0] s8;
    s8 = GEOM_W'(s);
    unique case (seg)
      SEG_MID: g = '{x0: 8'd1,      y0: s8 + 8'd2,        x1: s8 + 8'd1, y1: s8 + 8'd2};
      SEG_UR:  g = '{x0: s8 + 8'd2, y0: 8'd1,             x1: s8 + 8'd2, y1: s8 + 8'd1};
      SEG_TOP: g = '{x0: 8'd1,      y0: 8'd0,             x1: s8 + 8'd1, y1: 8'd0};
      SEG_UL:  g = '{x0: 8'd0,      y0: 8'd1,             x1: 8'd0,      y1: s8 + 8'd1};
      SEG_LL:  g = '{x0: 8'd0,      y0: s8 + 8'd3,        x1: 8'd0,      y1: s8 + s8 + 8'd3};
      SEG_BOT: g = '{x0: 8'd1,      y0: s8 + s8 + 8'd4,   x1: s8 + 8'd1, y1: s8 + s8 + 8'd4};
      SEG_LR:  g = '{x0: s8 + 8'd2, y0: s8 + 8'd3,        x1: s8 + 8'd2, y1: s8 + s8 + 8'd3};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

/* hdl/ssnl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssnl_front
// Accepts a number, clamps it, converts it to BCD and queues the item.
// ----------------------------------------------------------------------------
`include "seven_segment_number_to_lines_core_assert.svh"

module ssnl_front
  import ssnl_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [NUM_W-1:0]                   number_value_i,
  input  logic [ORG_W-1:0]                   origin_x_i,
  input  logic [ORG_W-1:0]                   origin_y_i,
  input  logic [COLOR_W-1:0]                 pixel_color_i,
  output logic                               push_o,
  input  logic                               push_ready_i,
  output logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_o,
  output item_hdr_t                          hdr_o
);

  localparam longint unsigned MAX_VAL = max_value(MAX_DIGITS);
  localparam int SH_W = MAX_DIGITS * DIGIT_W + NUM_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CONV_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_PUSH = 3'b100
  } front_state_e;

  front_state_e                     state_q, state_d;
  logic [STEP_W-1:0]                step_q, step_d;
  logic [NUM_W-1:0]                 bin_q, bin_d;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] bcd_q, bcd_d;
  logic [ORG_W-1:0]                 ox_q, oy_q;
  logic [COLOR_W-1:0]               color_q;
  logic                             accept;
  logic [NUM_W-1:0]                 num_clamped;
  logic [SH_W-1:0]                  sh;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] dab;
  logic [DIGIT_CNT_W-1:0]           count;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (state_q == S_PUSH);

  always_comb begin
    if (64'(number_value_i) > MAX_VAL) begin
      num_clamped = MAX_VAL[NUM_W-1:0];
    end else begin
      num_clamped = number_value_i;
    end
  end

  // Double dabble, several bits per step.
  always_comb begin
    sh = {bcd_q, bin_q};
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      dab = sh[SH_W-1 -: MAX_DIGITS*DIGIT_W];
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (dab[d] >= 4'd5) begin
          dab[d] = dab[d] + 4'd3;
        end
      end
      sh = {dab, sh[NUM_W-1:0]} << 1;
    end
  end

  // Digit count: position of the highest nonzero digit, at least one.
  always_comb begin
    count = DIGIT_CNT_W'(1);
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (bcd_q[d] != '0) begin
        count = DIGIT_CNT_W'(d + 1);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CONV;
          step_d  = '0;
          bin_d   = num_clamped;
          bcd_d   = '0;
        end
      end
      S_CONV: begin
        {bcd_d, bin_d} = sh;
        step_d         = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (push_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    if (accept) begin
      ox_q    <= origin_x_i;
      oy_q    <= origin_y_i;
      color_q <= pixel_color_i;
    end
  end

  assign digits_o    = bcd_q;
  assign hdr_o.count = count;
  assign hdr_o.ox    = ox_q;
  assign hdr_o.oy    = oy_q;
  assign hdr_o.color = color_q;

  `SSNL_ASSERT_NEXT(a_accept_starts_conv, accept, state_q == S_CONV)
  `SSNL_ASSERT_IMPL(a_count_in_range, push_o,
                    (count != '0) && (count <= DIGIT_CNT_W'(MAX_DIGITS)))

endmodule

/* hdl/ssnl_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssnl_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module ssnl_fifo
  import ssnl_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/ssnl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssnl_back
// Walks the lit segments of each digit and emits one line per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`include "seven_segment_number_to_lines_core_assert.svh"

module ssnl_back
  import ssnl_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [SEG_LEN_W-1:0]               seg_len_i,
  input  logic                               q_valid_i,
  output logic                               q_pop_o,
  input  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] q_digits_i,
  input  item_hdr_t                          q_hdr_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [COORD_W-1:0]                 start_x_o,
  output logic [COORD_W-1:0]                 start_y_o,
  output logic [COORD_W-1:0]                 end_x_o,
  output logic [COORD_W-1:0]                 end_y_o,
  output logic [COLOR_W-1:0]                 line_color_o,
  output logic [DIGIT_CNT_W-1:0]             digit_count_o,
  output logic                               last_line_o
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                               busy_q;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digs_q;
  logic [IDX_W-1:0]                   ridx_q;
  logic [NUM_SEGS-1:0]                seg_rem_q;
  logic [COORD_W-1:0]                 xoff_q;
  logic [ORG_W-1:0]                   oy_q;
  logic [COLOR_W-1:0]                 color_q;
  logic [DIGIT_CNT_W-1:0]             cnt_q;
  logic                               out_valid_q;

  logic                 advance;
  logic                 load;
  seg_e                 cur_seg;
  logic [NUM_SEGS-1:0]  seg_left;
  logic [IDX_W-1:0]     ridx_dn;
  logic [IDX_W-1:0]     load_idx;
  logic                 digit_done;
  logic                 item_done;
  seg_geom_t            geom;
  logic [COORD_W-1:0]   oy13;

  assign advance    = busy_q && (!out_valid_q || !out_stall_i);
  assign load       = !busy_q && q_valid_i;
  assign q_pop_o    = load;
  assign seg_left   = seg_rem_q & (seg_rem_q - 1'b1);
  assign ridx_dn    = ridx_q - 1'b1;
  assign load_idx   = IDX_W'(q_hdr_i.count - 1'b1);
  assign digit_done = (seg_left == '0);
  assign item_done  = digit_done && (ridx_q == '0);
  assign oy13       = COORD_W'(oy_q);
  assign geom       = seg_geom(cur_seg, seg_len_i);

  // Lowest lit segment still to draw.
  always_comb begin
    cur_seg = SEG_MID;
    for (int i = NUM_SEGS - 1; i >= 0; i--) begin
      if (seg_rem_q[i]) begin
        cur_seg = seg_e'(i[2:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
      end else if (advance && item_done) begin
        busy_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      digs_q    <= q_digits_i;
      ridx_q    <= load_idx;
      seg_rem_q <= seg_mask(q_digits_i[load_idx]);
      xoff_q    <= COORD_W'(q_hdr_i.ox);
      oy_q      <= q_hdr_i.oy;
      color_q   <= q_hdr_i.color;
      cnt_q     <= q_hdr_i.count;
    end else if (advance) begin
      if (digit_done) begin
        // Step to the next digit to the right.
        ridx_q    <= ridx_dn;
        seg_rem_q <= seg_mask(digs_q[ridx_dn]);
        xoff_q    <= xoff_q + COORD_W'(seg_len_i) + DIGIT_GAP;
      end else begin
        seg_rem_q <= seg_left;
      end
    end
    if (advance) begin
      start_x_o     <= xoff_q + COORD_W'(geom.x0);
      start_y_o     <= oy13 + COORD_W'(geom.y0);
      end_x_o       <= xoff_q + COORD_W'(geom.x1);
      end_y_o       <= oy13 + COORD_W'(geom.y1);
      line_color_o  <= color_q;
      digit_count_o <= cnt_q;
      last_line_o   <= item_done;
    end
  end

  assign out_valid_o = out_valid_q;

  `SSNL_ASSERT_IMPL(a_busy_has_segment, busy_q, seg_rem_q != '0)
  `SSNL_ASSERT_IMPL(a_index_below_count, busy_q, DIGIT_CNT_W'(ridx_q) < cnt_q)
  `SSNL_ASSERT_IMPL(a_pop_only_when_free, q_pop_o, !busy_q)

endmodule

/* hdl/seven_segment_number_to_lines_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_number_to_lines_core
// Number to seven-segment line list: one output beat per lit segment.
// ----------------------------------------------------------------------------
// Each input beat carries a number, a screen origin and a color; the core
// answers with one output beat per lit segment, most significant digit first
// and segments in bit order within a digit, with last_line_o set on the final
// beat of the number. Numbers above 10^MAX_DIGITS-1 show as all nines. The
// front converts the number to BCD three bits per cycle: it accepts the item,
// runs the conversion steps and then writes the item into the queue, waiting
// there while the queue is full. The back picks the item up from the queue and
// then emits one line per cycle unless the output stalls, one line per lit
// segment (from 2 to 7 per digit). A QUEUE_DEPTH-entry queue lets the front
// convert the next number while the back still draws this one. segment_length
// is to be written over the config channel (always ready) only while the core
// is idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module seven_segment_number_to_lines_core
  import ssnl_pkg::*;
#(
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config channel: segment length
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [SEG_LEN_W-1:0]   cfg_data_i,
  // input beats
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [NUM_W-1:0]       number_value_i,
  input  logic [ORG_W-1:0]       origin_x_i,
  input  logic [ORG_W-1:0]       origin_y_i,
  input  logic [COLOR_W-1:0]     pixel_color_i,
  // output beats
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [COORD_W-1:0]     start_x_o,
  output logic [COORD_W-1:0]     start_y_o,
  output logic [COORD_W-1:0]     end_x_o,
  output logic [COORD_W-1:0]     end_y_o,
  output logic [COLOR_W-1:0]     line_color_o,
  output logic [DIGIT_CNT_W-1:0] digit_count_o,
  output logic                   last_line_o
);

  localparam int DIG_BITS = MAX_DIGITS * DIGIT_W;
  localparam int Q_W      = DIG_BITS + $bits(item_hdr_t);

  logic [SEG_LEN_W-1:0] seg_len_q;

  logic                               f_push;
  logic                               f_ready;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] f_digits;
  item_hdr_t                          f_hdr;
  logic                               q_valid;
  logic                               q_pop;
  logic [Q_W-1:0]                     q_rdata;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] q_digits;
  item_hdr_t                          q_hdr;

  // The register is to be written only while idle; the block does not enforce this, so take every write at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_len_q <= SEG_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      seg_len_q <= cfg_data_i;
    end
  end

  // Front: clamp and BCD conversion.
  ssnl_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .number_value_i (number_value_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .pixel_color_i  (pixel_color_i),
    .push_o         (f_push),
    .push_ready_i   (f_ready),
    .digits_o       (f_digits),
    .hdr_o          (f_hdr)
  );

  // Queue: digits and item header packed into one word.
  ssnl_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .ready_o (f_ready),
    .wdata_i ({f_digits, f_hdr}),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rdata_o (q_rdata)
  );

  assign {q_digits, q_hdr} = q_rdata;

  // Back: segment walk and output register.
  ssnl_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seg_len_i     (seg_len_q),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_digits_i    (q_digits),
    .q_hdr_i       (q_hdr),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .start_x_o     (start_x_o),
    .start_y_o     (start_y_o),
    .end_x_o       (end_x_o),
    .end_y_o       (end_y_o),
    .line_color_o  (line_color_o),
    .digit_count_o (digit_count_o),
    .last_line_o   (last_line_o)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the seven-segment number-to-lines core.
// ----------------------------------------------------------------------------
// Numbers, origins and colors are pushed into the core one beat at a time.
// A scoreboard works out the line list of every accepted number: it clamps
// the number, splits it into digits and places each lit segment. It then
// checks every line beat that comes out, in order and field by field. A short
// directed run covers the edge values and every font size extreme. Random
// phases follow, each with a new font size and one of the idle patterns in turn,
// cycling through sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import ssnl_pkg::*;

  localparam int          CLK_PERIOD      = 10;
  localparam int          RESET_CYCLES    = 8;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          TAIL_CYCLES     = 50;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          NUM_PHASES      = 8;
  localparam int          ITEMS_PER_PHASE = 52;
  localparam longint      TIMEOUT_NS      = 64'd5_000_000;
  localparam int unsigned BUSY_PCT        = 57;
  localparam int unsigned LIGHT_PCT       = 7;

  // Lit segments of each decimal digit; entry d sits at index d.
  localparam logic [9:0][NUM_SEGS-1:0] DIGIT_SEGS = {
    7'd79, 7'd127, 7'd70, 7'd125, 7'd109, 7'd75, 7'd103, 7'd55, 7'd66, 7'd126
  };

  // Who idles in the current phase.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } traffic_e;

  typedef struct {
    logic [COORD_W-1:0]     sx;
    logic [COORD_W-1:0]     sy;
    logic [COORD_W-1:0]     ex;
    logic [COORD_W-1:0]     ey;
    logic [COLOR_W-1:0]     color;
    logic [DIGIT_CNT_W-1:0] count;
    logic                   last;
  } seg_line_t;

  // --------------------------------------------------------------------------
  // Scoreboard: expands each accepted number into its line list and checks
  // the line beats against it, oldest first.
  // --------------------------------------------------------------------------
  class seg_line_board;
    seg_line_t            expected_lines[$];
    logic [SEG_LEN_W-1:0] seg_length;
    int unsigned          errors;

    function new();
      seg_length = SEG_LEN_RESET;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return expected_lines.size();
    endfunction

    // Queue the lines one accepted number should draw with the current size.
    function void note_number(input logic [NUM_W-1:0] num, input logic [ORG_W-1:0] ox,
                              input logic [ORG_W-1:0] oy, input logic [COLOR_W-1:0] color);
      seg_line_t       drawn[$];
      seg_line_t       ln;
      logic [3:0]      lsd_first[MAX_DIGITS_DEF];
      longint unsigned rest;
      longint unsigned ceiling;
      int unsigned     s, xoff, x0, y0, x1, y1, d;
      int              nd;
      ceiling = 1;
      for (int k = 0; k < MAX_DIGITS_DEF; k++) begin
        ceiling = ceiling * 10;
      end
      ceiling = ceiling - 1;
      // Anything past the widest display shows as all nines.
      rest = (num > ceiling) ? ceiling : num;
      nd = 0;
      do begin
        lsd_first[nd] = 4'(rest % 10);
        rest = rest / 10;
        nd++;
      end while (rest != 0 && nd < MAX_DIGITS_DEF);
      s = int'(seg_length);
      for (int j = 0; j < nd; j++) begin
        d    = int'(lsd_first[nd-1-j]);
        xoff = int'(ox) + j * (int'(DIGIT_GAP) + s);
        for (int i = 0; i < NUM_SEGS; i++) begin
          if (!DIGIT_SEGS[d][i]) continue;
          case (seg_e'(i))
            SEG_MID: begin
              x0 = 1;     y0 = s + 2;         x1 = s + 1; y1 = s + 2;
            end
            SEG_UR: begin
              x0 = s + 2; y0 = 1;             x1 = s + 2; y1 = s + 1;
            end
            SEG_TOP: begin
              x0 = 1;     y0 = 0;             x1 = s + 1; y1 = 0;
            end
            SEG_UL: begin
              x0 = 0;     y0 = 1;             x1 = 0;     y1 = s + 1;
            end
            SEG_LL: begin
              x0 = 0;     y0 = s + 3;         x1 = 0;     y1 = 2 * s + 3;
            end
            SEG_BOT: begin
              x0 = 1;     y0 = 2 * s + 4;     x1 = s + 1; y1 = 2 * s + 4;
            end
            default: begin
              x0 = s + 2; y0 = s + 3;         x1 = s + 2; y1 = 2 * s + 3;
            end
          endcase
          ln.sx    = COORD_W'(xoff + x0);
          ln.sy    = COORD_W'(int'(oy) + y0);
          ln.ex    = COORD_W'(xoff + x1);
          ln.ey    = COORD_W'(int'(oy) + y1);
          ln.color = color;
          ln.count = DIGIT_CNT_W'(nd);
          ln.last  = 1'b0;
          drawn.push_back(ln);
        end
      end
      foreach (drawn[k]) begin
        ln      = drawn[k];
        ln.last = (k == drawn.size() - 1);
        expected_lines.push_back(ln);
      end
    endfunction

    function void compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_line(input seg_line_t got);
      seg_line_t want;
      if (expected_lines.size() == 0) begin
        $error("line beat with no line pending: start_x %0d start_y %0d", got.sx, got.sy);
        errors++;
        return;
      end
      want = expected_lines.pop_front();
      compare_field("start_x", 32'(want.sx), 32'(got.sx));
      compare_field("start_y", 32'(want.sy), 32'(got.sy));
      compare_field("end_x", 32'(want.ex), 32'(got.ex));
      compare_field("end_y", 32'(want.ey), 32'(got.ey));
      compare_field("line_color", want.color, got.color);
      compare_field("digit_count", 32'(want.count), 32'(got.count));
      compare_field("last_line", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic [SEG_LEN_W-1:0]   cfg_data_i     = '0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  logic [NUM_W-1:0]       number_value_i = '0;
  logic [ORG_W-1:0]       origin_x_i     = '0;
  logic [ORG_W-1:0]       origin_y_i     = '0;
  logic [COLOR_W-1:0]     pixel_color_i  = '0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic [COORD_W-1:0]     start_x_o;
  logic [COORD_W-1:0]     start_y_o;
  logic [COORD_W-1:0]     end_x_o;
  logic [COORD_W-1:0]     end_y_o;
  logic [COLOR_W-1:0]     line_color_o;
  logic [DIGIT_CNT_W-1:0] digit_count_o;
  logic                   last_line_o;

  seg_line_board board;
  traffic_e      traffic      = IDLE_NONE;
  // Set by the stimulus to start one long receiver hold-off.
  bit            hold_request = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  seven_segment_number_to_lines_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .number_value_i (number_value_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .pixel_color_i  (pixel_color_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .start_x_o      (start_x_o),
    .start_y_o      (start_y_o),
    .end_x_o        (end_x_o),
    .end_y_o        (end_y_o),
    .line_color_o   (line_color_o),
    .digit_count_o  (digit_count_o),
    .last_line_o    (last_line_o)
  );

  // Idle odds per cycle: heavy on the side the phase names, light when both.
  function automatic bit sender_gap();
    int unsigned pct;
    pct = (traffic == IDLE_SENDER) ? BUSY_PCT : (traffic == IDLE_BOTH) ? LIGHT_PCT : 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit receiver_busy();
    int unsigned pct;
    pct = (traffic == IDLE_RECEIVER) ? BUSY_PCT : (traffic == IDLE_BOTH) ? LIGHT_PCT : 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  // Mostly well-formed numbers of a random digit count; some raw 27-bit words,
  // which often land above the display range and get clamped.
  function automatic logic [NUM_W-1:0] random_number();
    int unsigned     nd;
    longint unsigned lo;
    longint unsigned hi;
    if ($urandom_range(0, 99) < 12) return NUM_W'($urandom());
    nd = $urandom_range(1, MAX_DIGITS_DEF);
    lo = 1;
    for (int k = 1; k < nd; k++) begin
      lo = lo * 10;
    end
    hi = lo * 10 - 1;
    if (nd == 1) lo = 0;
    return NUM_W'(lo + $urandom_range(0, int'(hi - lo)));
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: stall at random, or hold off for a long stretch on request so
  // the core's queue fills up and it has to stall its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= receiver_busy();
      end
    end
  end

  // Check every line beat the core hands over.
  always @(posedge clk_i) begin : line_monitor
    seg_line_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.sx    = start_x_o;
      seen.sy    = start_y_o;
      seen.ex    = end_x_o;
      seen.ey    = end_y_o;
      seen.color = line_color_o;
      seen.count = digit_count_o;
      seen.last  = last_line_o;
      board.check_line(seen);
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks; all are entered and left right after a rising edge.
  // --------------------------------------------------------------------------

  // Offer one number beat and hold it until the core takes it. Valid stays
  // high across back-to-back beats and drops only for a gap.
  task automatic offer_number(input logic [NUM_W-1:0] num, input logic [ORG_W-1:0] ox,
                              input logic [ORG_W-1:0] oy, input logic [COLOR_W-1:0] color);
    if (sender_gap()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (sender_gap()) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    number_value_i <= num;
    origin_x_i     <= ox;
    origin_y_i     <= oy;
    pixel_color_i  <= color;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_number(num, ox, oy, color);
  endtask

  // Drop valid and wait until every expected line has come out.
  task automatic drain_lines();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Change the font size only once the core has gone quiet.
  task automatic program_length(input logic [SEG_LEN_W-1:0] len);
    drain_lines();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.seg_length = len;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [SEG_LEN_W-1:0] len;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed run at the reset font size: zero, every digit, range edges,
    // clamping and the extreme coordinates and colors.
    offer_number(NUM_W'(0), 12'd0, 12'd0, 32'h0000_0000);
    offer_number(NUM_W'(7), 12'd100, 12'd200, 32'h1234_5678);
    offer_number(NUM_W'(12345678), 12'd10, 12'd20, 32'hFFFF_FFFF);
    offer_number(NUM_W'(90), 12'd4095, 12'd0, 32'h8000_0001);
    offer_number(NUM_W'(99999999), 12'd0, 12'd4095, 32'hDEAD_BEEF);
    offer_number(NUM_W'(100000000), 12'd1, 12'd1, 32'h0F0F_0F0F);
    offer_number({NUM_W{1'b1}}, 12'd2048, 12'd2048, 32'hF0F0_F0F0);
    offer_number(NUM_W'(10), 12'd5, 12'd6, 32'h0000_0001);
    offer_number(NUM_W'(10000000), 12'd300, 12'd400, 32'hCAFE_F00D);
    offer_number(NUM_W'(9999999), 12'd7, 12'd8, 32'h7FFF_FFFF);
    offer_number(NUM_W'(88888888), 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    offer_number(NUM_W'(1), 12'd0, 12'd0, 32'h0000_0000);
    offer_number(NUM_W'(55555555), 12'hAAA, 12'h555, 32'hA5A5_A5A5);
    offer_number(NUM_W'(46464646), 12'h555, 12'hAAA, 32'h5A5A_5A5A);

    // Largest font: widest spacing and the highest coordinates.
    program_length(6'd63);
    offer_number(NUM_W'(88888888), 12'd4095, 12'd4095, 32'hFFFF_FFFF);
    offer_number(NUM_W'(0), 12'd4095, 12'd0, 32'h0000_0000);
    offer_number(NUM_W'(2147483), 12'd1000, 12'd3000, 32'h1357_9BDF);

    // Zero-length segments still get placed by the formulas.
    program_length(6'd0);
    offer_number(NUM_W'(88888888), 12'd0, 12'd0, 32'h2468_ACE0);
    offer_number(NUM_W'(8), 12'd4095, 12'd4095, 32'hFFFF_0000);

    program_length(6'd1);
    offer_number(NUM_W'(18), 12'd4095, 12'd4095, 32'h0000_FFFF);
    offer_number(NUM_W'(36925814), 12'd123, 12'd456, 32'h0BAD_CAFE);

    // Random phases: a fresh font size each, cycling through the idle patterns.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: len = SEG_LEN_RESET;
        1: len = 6'd63;
        2: len = 6'd1;
        3: len = 6'd0;
        default: len = SEG_LEN_W'($urandom_range(1, 63));
      endcase
      program_length(len);
      traffic = traffic_e'(phase % 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Back-pressure: the receiver holds off while beats keep coming.
        if (phase == 0 && n == 8) hold_request = 1'b1;
        // Pause the sender until the core has emptied out completely.
        if (phase == 1 && n == 26) drain_lines();
        offer_number(random_number(), ORG_W'($urandom()), ORG_W'($urandom()), $urandom());
      end
    end

    drain_lines();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/ssnl_pkg.sv
hdl/ssnl_front.sv
hdl/ssnl_fifo.sv
hdl/ssnl_back.sv
hdl/seven_segment_number_to_lines_core.sv
tb/sv/testbench.sv
